@@ rtl/core/hscd_pkg.sv @@
// Package for the hi-res scanline colour decoder: line geometry, queue sizing,
// command and status structs, and the artifact colour lookup.
// No dependencies.
`timescale 1ns / 1ps

package hscd_pkg;

  localparam int BYTES_PER_LINE = 40;
  localparam int COL_W          = $clog2(BYTES_PER_LINE);

  localparam int CMDQ_DEPTH = 2;
  localparam int QPTR_W     = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int QCNT_W     = $clog2(CMDQ_DEPTH + 1);

  // Emission steps: held pixel 6, then own pixels 0..6
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] STEP_HELD = 3'd0;
  localparam logic [STEP_W-1:0] STEP_BIT0 = 3'd1;
  localparam logic [STEP_W-1:0] STEP_BIT5 = 3'd6;
  localparam logic [STEP_W-1:0] STEP_BIT6 = 3'd7;

  typedef struct packed {
    logic [7:0] video;
    logic [7:0] held;
    logic       col_odd;
    logic       first;
    logic       last;
  } hscd_cmd_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  typedef struct packed {
    logic              started;
    logic [STEP_W-1:0] step;
  } hscd_back_stat_t;

  localparam rgb_t RGB_BLACK  = '{r: 8'd0,   g: 8'd0,   b: 8'd0};
  localparam rgb_t RGB_WHITE  = '{r: 8'd255, g: 8'd255, b: 8'd255};
  localparam rgb_t RGB_PURPLE = '{r: 8'd200, g: 8'd64,  b: 8'd255};
  localparam rgb_t RGB_GREEN  = '{r: 8'd48,  g: 8'd200, b: 8'd64};
  localparam rgb_t RGB_BLUE   = '{r: 8'd64,  g: 8'd136, b: 8'd255};
  localparam rgb_t RGB_ORANGE = '{r: 8'd255, g: 8'd144, b: 8'd48};

  function automatic rgb_t pixel_colour(logic left, logic cur, logic right,
                                        logic phase, logic odd);
    rgb_t c;
    if (!cur) begin
      c = RGB_BLACK;
    end else if (left || right) begin
      c = RGB_WHITE;
    end else begin
      case ({phase, odd})
        2'b00:   c = RGB_PURPLE;
        2'b01:   c = RGB_GREEN;
        2'b10:   c = RGB_BLUE;
        default: c = RGB_ORANGE;
      endcase
    end
    return c;
  endfunction

endpackage

@@ rtl/core/hires_scanline_color_decoder_core.sv @@
// Top level of the hi-res scanline colour decoder: front end, command queue
// and pixel back end. Depends on hscd_pkg, hscd_front, hscd_cmd_fifo, hscd_back.
//
// Usage:
//   Input queue: drive video_byte and raise push; a request is taken at an edge
//   where push is high and full is low. Bytes arrive in column order,
//   BYTES_PER_LINE to a scanline.
//   Result queue: while empty is low the oldest pixel sits on red, green,
//   blue, last_of_run and line_end; pop at such an edge takes it.
//   Each byte yields six pixels (first byte of a line), seven (middle) or
//   eight (last byte, whose final pixel carries line_end). last_of_run marks
//   the final pixel of each byte.
//   Path: a taken byte is written into the command queue, and its first pixel
//   is then registered into the output register, if the back end is free.
//   Throughput: the back end emits one pixel per cycle while the output
//   register is empty or being popped; the front end takes a byte in any
//   cycle while the two-entry command queue has room.
//   Reset: clears the column count to the first byte of a line, the held
//   byte, the queue, the back-end step and the output valid flag.
//   Stall: with pop low the output register holds its pixel, the back end
//   stops, the queue fills and full rises until the receiver takes pixels.
`timescale 1ns / 1ps

module hires_scanline_color_decoder_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] video_byte,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] red,
  output logic [7:0] green,
  output logic [7:0] blue,
  output logic       last_of_run,
  output logic       line_end
);
  import hscd_pkg::*;

  hscd_cmd_t         front_cmd;
  hscd_cmd_t         head_cmd;
  logic              q_push;
  logic              q_full;
  logic              q_valid;
  logic              q_pop;
  logic [QCNT_W-1:0] q_count;
  hscd_back_stat_t   back_stat;

  // Front end: classify each byte and queue a command for it
  hscd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .video_byte (video_byte),
    .q_full     (q_full),
    .full       (full),
    .q_push     (q_push),
    .cmd        (front_cmd)
  );

  // Hold pending commands so either side can stall on its own
  hscd_cmd_fifo u_cmdq (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_push),
    .wr_data (front_cmd),
    .rd      (q_pop),
    .rd_data (head_cmd),
    .q_full  (q_full),
    .q_valid (q_valid),
    .q_count (q_count)
  );

  // Back end: advance one pixel per cycle unless the output register stalls
  hscd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd         (head_cmd),
    .cmd_valid   (q_valid),
    .cmd_pop     (q_pop),
    .pop         (pop),
    .empty       (empty),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .last_of_run (last_of_run),
    .line_end    (line_end),
    .stat        (back_stat)
  );

  // The rightmost pixel of a line always closes its byte
  a_line_end_closes_run: assert property (@(posedge clk) disable iff (rst)
    (!empty && line_end) |-> last_of_run)
    else $error("line_end without last_of_run");

  // A byte part-way through emission must still be at the queue head
  a_started_has_cmd: assert property (@(posedge clk) disable iff (rst)
    back_stat.started |-> q_valid)
    else $error("back end mid-byte with no command");

  // Queue occupancy stays within its depth
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= QCNT_W'(CMDQ_DEPTH))
    else $error("command queue overflow");

  // A popped command leaves the back end ready for the next byte
  a_pop_resets_step: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> !back_stat.started)
    else $error("back end still mid-byte after finishing a command");

endmodule

@@ rtl/core/hscd_front.sv @@
// Front end: accept display bytes, track the byte column and the held byte,
// and build one command per byte for the back end. Depends on hscd_pkg.
`timescale 1ns / 1ps

module hscd_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [7:0]        video_byte,
  input  logic              q_full,
  output logic              full,
  output logic              q_push,
  output hscd_pkg::hscd_cmd_t cmd
);
  import hscd_pkg::*;

  logic [7:0]       held_byte;
  logic [COL_W-1:0] byte_column;
  logic [COL_W-1:0] byte_column_next;
  logic             last_col;

  assign full     = q_full;
  assign q_push   = push && !q_full;
  assign last_col = (byte_column == COL_W'(BYTES_PER_LINE - 1));

  assign byte_column_next = last_col ? '0 : byte_column + 1'b1;

  assign cmd.video   = video_byte;
  assign cmd.held    = held_byte;
  assign cmd.col_odd = byte_column[0];
  assign cmd.first   = (byte_column == '0);
  assign cmd.last    = last_col;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_byte   <= '0;
      byte_column <= '0;
    end else if (q_push) begin
      held_byte   <= video_byte;
      byte_column <= byte_column_next;
    end
  end

endmodule

@@ rtl/core/hscd_cmd_fifo.sv @@
// Short command queue between the front and back ends.
// Depends on hscd_pkg.
`timescale 1ns / 1ps

module hscd_cmd_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr,
  input  hscd_pkg::hscd_cmd_t wr_data,
  input  logic                rd,
  output hscd_pkg::hscd_cmd_t rd_data,
  output logic                q_full,
  output logic                q_valid,
  output logic [hscd_pkg::QCNT_W-1:0] q_count
);
  import hscd_pkg::*;

  hscd_cmd_t         slots [CMDQ_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign q_count = count;
  assign q_full  = (count == QCNT_W'(CMDQ_DEPTH));
  assign q_valid = (count != '0);
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == QPTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == QPTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({wr, rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/core/hscd_back.sv @@
// Back end: step through one command a pixel per cycle unless the output
// register stalls, colour each pixel and register it. Depends on hscd_pkg.
`timescale 1ns / 1ps

module hscd_back (
  input  logic                clk,
  input  logic                rst,
  input  hscd_pkg::hscd_cmd_t cmd,
  input  logic                cmd_valid,
  output logic                cmd_pop,
  input  logic                pop,
  output logic                empty,
  output logic [7:0]          red,
  output logic [7:0]          green,
  output logic [7:0]          blue,
  output logic                last_of_run,
  output logic                line_end,
  output hscd_pkg::hscd_back_stat_t stat
);
  import hscd_pkg::*;

  logic              started;
  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] cur_step;
  logic [STEP_W-1:0] end_step;
  logic [9:0]        window;
  logic [9:0]        shifted;
  logic              phase;
  logic              odd;
  logic              advance;
  logic              at_end;
  logic              out_valid;
  rgb_t              colour;

  assign cur_step = started ? step : (cmd.first ? STEP_BIT0 : STEP_HELD);
  assign end_step = cmd.last ? STEP_BIT6 : STEP_BIT5;
  assign at_end   = (cur_step == end_step);

  // Neighbourhood window: held pixels 5 and 6, own pixels 0..6, right edge off
  assign window  = {1'b0, cmd.video[6:0], cmd.held[6] & !cmd.first, cmd.held[5]};
  assign shifted = window >> cur_step;
  assign phase   = (cur_step == STEP_HELD) ? cmd.held[7] : cmd.video[7];
  assign odd     = cmd.col_odd ^ ~cur_step[0];
  assign colour  = pixel_colour(shifted[0], shifted[1], shifted[2], phase, odd);

  assign advance = cmd_valid && (!out_valid || pop);
  assign cmd_pop = advance && at_end;
  assign empty   = !out_valid;

  assign stat.started = started;
  assign stat.step    = step;

  always_ff @(posedge clk) begin
    if (rst) begin
      started   <= 1'b0;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        started <= !at_end;
        step    <= cur_step + 1'b1;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      red         <= colour.r;
      green       <= colour.g;
      blue        <= colour.b;
      last_of_run <= at_end;
      line_end    <= (cur_step == STEP_BIT6);
    end
  end

endmodule
